@@ hw/rtl/sqpx_pkg.sv @@
`timescale 1ns / 1ps

package sqpx_pkg;

  localparam int VALUE_BITS  = 8;
  localparam int PRIME_COUNT = 54;
  localparam int SIEVE_SIZE  = 1 << VALUE_BITS;
  localparam int IN_W        = ((VALUE_BITS + 7) / 8) * 8;
  localparam int IDX_W       = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1;
  localparam int CNT_W       = $clog2(PRIME_COUNT + 1);
  localparam int PROD_W      = 2 * VALUE_BITS;
  localparam int RANK_W      = 6;
  localparam int COUNT_W     = 30;
  localparam int RANK_LSB    = 1;
  localparam int COUNT_LSB   = RANK_LSB + RANK_W;
  localparam int OUT_W       = ((COUNT_LSB + COUNT_W + 7) / 8) * 8;

  localparam logic [COUNT_W:0] MODULUS = 31'd1000000007;

  typedef logic [VALUE_BITS-1:0]  val_t;
  typedef logic [PROD_W-1:0]      prod_t;
  typedef logic [PRIME_COUNT-1:0] mask_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [COUNT_W-1:0]     count_t;
  typedef val_t prime_tab_t [PRIME_COUNT];

  typedef struct packed {
    logic                added;
    logic [RANK_W-1:0]   rank;
    count_t              count;
  } res_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_CHK,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_XOR,
    B_DONE
  } back_state_e;

  function automatic int count_primes();
    logic [SIEVE_SIZE-1:0] comp;
    int n;
    comp = '0;
    n = 0;
    for (int i = 2; i < SIEVE_SIZE; i++) begin
      if (!comp[i]) begin
        n++;
        for (int k = i * i; k < SIEVE_SIZE; k += i) begin
          comp[k] = 1'b1;
        end
      end
    end
    return n;
  endfunction

  function automatic prime_tab_t build_primes();
    logic [SIEVE_SIZE-1:0] comp;
    prime_tab_t tab;
    int n;
    comp = '0;
    n = 0;
    for (int j = 0; j < PRIME_COUNT; j++) begin
      tab[j] = '0;
    end
    for (int i = 2; i < SIEVE_SIZE; i++) begin
      if (!comp[i]) begin
        if (n < PRIME_COUNT) begin
          tab[n] = val_t'(i);
          n++;
        end
        for (int k = i * i; k < SIEVE_SIZE; k += i) begin
          comp[k] = 1'b1;
        end
      end
    end
    return tab;
  endfunction

  // Inverse of each odd prime modulo 2^VALUE_BITS, by Newton iteration.
  function automatic prime_tab_t build_inverses(prime_tab_t tab);
    prime_tab_t inv;
    val_t v;
    for (int j = 0; j < PRIME_COUNT; j++) begin
      v = tab[j];
      for (int r = 0; r < 4; r++) begin
        v = val_t'(v * val_t'(val_t'(2) - val_t'(tab[j] * v)));
      end
      inv[j] = tab[j][0] ? v : '0;
    end
    return inv;
  endfunction

  localparam int         PRIMES_BELOW = count_primes();
  localparam int         PRIME_USED   = (PRIMES_BELOW < PRIME_COUNT) ? PRIMES_BELOW : PRIME_COUNT;
  localparam cnt_t       PRIME_USED_C = cnt_t'(PRIME_USED);
  localparam prime_tab_t PRIME_TAB    = build_primes();
  localparam prime_tab_t INV_TAB      = build_inverses(PRIME_TAB);

endpackage

@@ hw/rtl/square_parity_xor_basis_rank_top.sv @@
`timescale 1ns / 1ps
// Channel   Direction  tdata bits (lowest first)                         tuser  tlast
// s_axis    in         value [7:0]                                       -      -
// m_axis    out        added_to_basis [0], rank [6:1], subset_count [36:7],
//                      zero [39:37]                                      -      -
//
// The front steps through every table prime not above the remaining cofactor, passing a multiply
// and a check state for each, and passes both again for every division by a prime factor.
// The back scans the prime indices in turn and adds an XOR state for every basis row read from
// the row memory, so either side may set the pace for a given value.
// A two-entry queue between front and back and the output register let each side stall alone.
// After reset the basis is empty at once; row valid flags replace any clearing pass.

module square_parity_xor_basis_rank_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sqpx_pkg::IN_W-1:0]     s_axis_tdata,  // value
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sqpx_pkg::OUT_W-1:0]    m_axis_tdata   // added_to_basis, rank, subset_count
);

  logic            push_valid, push_ready;
  sqpx_pkg::mask_t push_mask;
  logic            pop_valid, pop_ready;
  sqpx_pkg::mask_t pop_mask;
  sqpx_pkg::res_t  res;

  sqpx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_value_i   (s_axis_tdata[sqpx_pkg::VALUE_BITS-1:0]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_mask_o  (push_mask)
  );

  sqpx_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_mask_i  (push_mask),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_mask_o   (pop_mask)
  );

  sqpx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_mask_i  (pop_mask),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[0] = res.added;
    m_axis_tdata[sqpx_pkg::COUNT_LSB-1:sqpx_pkg::RANK_LSB] = res.rank;
    m_axis_tdata[sqpx_pkg::COUNT_LSB+sqpx_pkg::COUNT_W-1:sqpx_pkg::COUNT_LSB] = res.count;
  end

endmodule

@@ hw/rtl/sqpx_ram.sv @@
`timescale 1ns / 1ps

module sqpx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/sqpx_front.sv @@
`timescale 1ns / 1ps

module sqpx_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sqpx_pkg::val_t     in_value_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output sqpx_pkg::mask_t    push_mask_o
);

  sqpx_pkg::front_state_e state_q, state_d;
  sqpx_pkg::val_t  x_q, x_d;
  sqpx_pkg::val_t  prod_q, prod_d;
  sqpx_pkg::cnt_t  j_q, j_d;
  sqpx_pkg::mask_t mask_q, mask_d;

  sqpx_pkg::idx_t  j_idx;
  sqpx_pkg::val_t  prime;
  sqpx_pkg::prod_t chk;
  logic            divisible;

  assign j_idx = j_q[sqpx_pkg::IDX_W-1:0];
  assign prime = sqpx_pkg::PRIME_TAB[j_idx];
  assign chk   = sqpx_pkg::prod_t'(prod_q) * sqpx_pkg::prod_t'(prime);

  always_comb begin
    if (j_q == '0) begin
      divisible = ~x_q[0];
    end else begin
      divisible = (chk[sqpx_pkg::PROD_W-1:sqpx_pkg::VALUE_BITS] == '0);
    end
  end

  always_comb begin
    state_d      = state_q;
    x_d          = x_q;
    prod_d       = prod_q;
    j_d          = j_q;
    mask_d       = mask_q;
    in_ready_o   = 1'b0;
    push_valid_o = 1'b0;
    unique case (state_q)
      sqpx_pkg::F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          x_d     = in_value_i;
          j_d     = '0;
          mask_d  = '0;
          state_d = sqpx_pkg::F_MUL;
        end
      end
      sqpx_pkg::F_MUL: begin
        if (j_q == sqpx_pkg::PRIME_USED_C || prime > x_q) begin
          state_d = sqpx_pkg::F_PUSH;
        end else begin
          if (j_q == '0) begin
            prod_d = x_q >> 1;
          end else begin
            prod_d = sqpx_pkg::val_t'(x_q * sqpx_pkg::INV_TAB[j_idx]);
          end
          state_d = sqpx_pkg::F_CHK;
        end
      end
      sqpx_pkg::F_CHK: begin
        if (divisible) begin
          x_d           = prod_q;
          mask_d[j_idx] = ~mask_q[j_idx];
        end else begin
          j_d = sqpx_pkg::cnt_t'(j_q + 1'b1);
        end
        state_d = sqpx_pkg::F_MUL;
      end
      sqpx_pkg::F_PUSH: begin
        push_valid_o = 1'b1;
        if (push_ready_i) begin
          state_d = sqpx_pkg::F_IDLE;
        end
      end
      default: state_d = sqpx_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sqpx_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    prod_q <= prod_d;
    j_q    <= j_d;
    mask_q <= mask_d;
  end

  assign push_mask_o = mask_q;

endmodule

@@ hw/rtl/sqpx_queue.sv @@
`timescale 1ns / 1ps

module sqpx_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  sqpx_pkg::mask_t push_mask_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output sqpx_pkg::mask_t pop_mask_o
);

  sqpx_pkg::mask_t slot_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      used_q;
  logic            push, pop;

  assign push_ready_o = (used_q != 2'd2);
  assign pop_valid_o  = (used_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_mask_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      used_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      used_q <= 2'(used_q + {1'b0, push} - {1'b0, pop});
    end
  end

endmodule

@@ hw/rtl/sqpx_back.sv @@
`timescale 1ns / 1ps

module sqpx_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  sqpx_pkg::mask_t pop_mask_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sqpx_pkg::res_t  out_res_o
);

  sqpx_pkg::back_state_e state_q, state_d;
  sqpx_pkg::mask_t mask_q, mask_d;
  sqpx_pkg::cnt_t  j_q, j_d;
  logic            added_q, added_d;
  sqpx_pkg::mask_t valid_q, valid_d;
  sqpx_pkg::cnt_t  rank_q, rank_d;
  sqpx_pkg::count_t count_q, count_d;
  logic            out_valid_q, out_valid_d;
  sqpx_pkg::res_t  res_q, res_d;

  sqpx_pkg::idx_t  j_idx;
  logic            ram_we;
  sqpx_pkg::mask_t row;
  logic [sqpx_pkg::COUNT_W:0] dbl;
  sqpx_pkg::count_t dbl_mod;

  assign j_idx = j_q[sqpx_pkg::IDX_W-1:0];

  sqpx_ram #(
    .WIDTH(sqpx_pkg::PRIME_COUNT),
    .DEPTH(sqpx_pkg::PRIME_COUNT)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (j_idx),
    .wdata_i (mask_q),
    .raddr_i (j_idx),
    .rdata_o (row)
  );

  assign dbl     = {count_q, 1'b0};
  assign dbl_mod = (dbl >= sqpx_pkg::MODULUS) ?
                   sqpx_pkg::count_t'(dbl - sqpx_pkg::MODULUS) :
                   sqpx_pkg::count_t'(dbl);

  always_comb begin
    state_d     = state_q;
    mask_d      = mask_q;
    j_d         = j_q;
    added_d     = added_q;
    valid_d     = valid_q;
    rank_d      = rank_q;
    count_d     = count_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    pop_ready_o = 1'b0;
    ram_we      = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      sqpx_pkg::B_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          mask_d  = pop_mask_i;
          j_d     = '0;
          added_d = 1'b0;
          state_d = sqpx_pkg::B_SCAN;
        end
      end
      sqpx_pkg::B_SCAN: begin
        if (j_q == sqpx_pkg::PRIME_USED_C) begin
          state_d = sqpx_pkg::B_DONE;
        end else if (mask_q[j_idx]) begin
          if (valid_q[j_idx]) begin
            state_d = sqpx_pkg::B_XOR;
          end else begin
            ram_we         = 1'b1;
            valid_d[j_idx] = 1'b1;
            added_d        = 1'b1;
            state_d        = sqpx_pkg::B_DONE;
          end
        end else begin
          j_d = sqpx_pkg::cnt_t'(j_q + 1'b1);
        end
      end
      sqpx_pkg::B_XOR: begin
        mask_d  = mask_q ^ row;
        j_d     = sqpx_pkg::cnt_t'(j_q + 1'b1);
        state_d = sqpx_pkg::B_SCAN;
      end
      sqpx_pkg::B_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          rank_d      = sqpx_pkg::cnt_t'(rank_q + sqpx_pkg::cnt_t'(added_q));
          count_d     = added_q ? count_q : dbl_mod;
          res_d.added = added_q;
          res_d.rank  = sqpx_pkg::RANK_W'(rank_d);
          res_d.count = count_d;
          out_valid_d = 1'b1;
          state_d     = sqpx_pkg::B_IDLE;
        end
      end
      default: state_d = sqpx_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sqpx_pkg::B_IDLE;
      valid_q     <= '0;
      rank_q      <= '0;
      count_q     <= sqpx_pkg::count_t'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      rank_q      <= rank_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q  <= mask_d;
    j_q     <= j_d;
    added_q <= added_d;
    res_q   <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

@@ hw/rtl/sqpx_checker.sv @@
`timescale 1ns / 1ps

module sqpx_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [sqpx_pkg::OUT_W-1:0] m_axis_tdata
);

  logic                            out_acc;
  logic                            added;
  logic [sqpx_pkg::RANK_W-1:0]     rank, prev_rank_q;
  sqpx_pkg::count_t                count, prev_count_q, exp_dbl;
  logic [sqpx_pkg::COUNT_W:0]      dbl;

  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign added   = m_axis_tdata[0];
  assign rank    = m_axis_tdata[sqpx_pkg::COUNT_LSB-1:sqpx_pkg::RANK_LSB];
  assign count   = m_axis_tdata[sqpx_pkg::COUNT_LSB+sqpx_pkg::COUNT_W-1:sqpx_pkg::COUNT_LSB];
  assign dbl     = {prev_count_q, 1'b0};
  assign exp_dbl = (dbl >= sqpx_pkg::MODULUS) ?
                   sqpx_pkg::count_t'(dbl - sqpx_pkg::MODULUS) :
                   sqpx_pkg::count_t'(dbl);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_rank_q  <= '0;
      prev_count_q <= sqpx_pkg::count_t'(1);
    end else if (out_acc) begin
      prev_rank_q  <= rank;
      prev_count_q <= count;
    end
  end

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  a_added: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && added |->
      rank == sqpx_pkg::RANK_W'(prev_rank_q + 1'b1) && count == prev_count_q)
    else $error("new basis row without rank step or with count change");

  a_dependent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !added |-> rank == prev_rank_q && count == exp_dbl)
    else $error("dependent item without doubled count or with rank change");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> {1'b0, count} < sqpx_pkg::MODULUS)
    else $error("subset count out of range");

endmodule

bind square_parity_xor_basis_rank_top sqpx_checker u_sqpx_checker (.*);
